>>> rtl/bvhms_pkg.sv
// Shared types and constants for the BVH midpoint split pass.
// Holds the request and result payload structs and the register index codes.
// No dependencies.
package bvhms_pkg;

    // Padding added around the first vertex of an empty child box: 0.1 in Q16.16.
    localparam int BOX_PAD = 6554;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_HALF_X   = 3'd3,
        CFG_HALF_Y   = 3'd4,
        CFG_HALF_Z   = 3'd5,
        CFG_FIRST    = 3'd6
    } t_cfg_idx;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic KIND_PLACE = 1'b0;
    localparam logic KIND_BOX   = 1'b1;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic               final_tri;
    } t_tri_in;

    typedef struct packed {
        logic               kind;
        logic               side;
        logic [23:0]        slot;
        logic signed [31:0] box_center_x;
        logic signed [31:0] box_center_y;
        logic signed [31:0] box_center_z;
        logic [30:0]        box_half_x;
        logic [30:0]        box_half_y;
        logic [30:0]        box_half_z;
        logic [16:0]        child_count;
        logic               run_end;
    } t_res_out;

endpackage

>>> rtl/bvh_midpoint_split_pass.sv
// BVH midpoint split pass: classifies one triangle per cycle against the parent
// centre and accumulates both child boxes. Depends on bvhms_pkg.
//
// A triangle is taken on every cycle in which the output register is free or is
// being emptied and no child box request is pending; its placement request
// appears in the next cycle. The node's final triangle is followed by two child
// box requests from the same output register, and input is held off until the
// second of them has been loaded into it. The sustained rate is one triangle per
// cycle within a node while the output is not stalled. The split state returns
// to empty at the final triangle with no clearing pass. Parameter COORD_BITS
// sets how many low coordinate bits are used (up to 32), MAX_NODE_TRIANGLES the
// saturation point of the counters. Configuration writes are always accepted.
module bvh_midpoint_split_pass
    import bvhms_pkg::*;
#(
    parameter int MAX_NODE_TRIANGLES = 65536,
    parameter int COORD_BITS         = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_tri_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_res_out             o_out_data
);

    localparam int CW    = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int CNT_W = $clog2(MAX_NODE_TRIANGLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NODE_TRIANGLES);
    localparam logic signed [CW:0] PAD = (CW+1)'(BOX_PAD);

    typedef logic signed [CW-1:0] t_coord;
    typedef enum logic [1:0] {PH_IDLE, PH_BOX0, PH_BOX1} t_phase;

    localparam t_coord C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam t_coord C_MAX = {1'b0, {(CW-1){1'b1}}};

    function automatic t_coord clamp_c(input logic signed [CW:0] v);
        t_coord r;
        if (v[CW] != v[CW-1]) begin
            r = v[CW] ? C_MIN : C_MAX;
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    function automatic t_coord min_c(input t_coord a, input t_coord b);
        return (b < a) ? b : a;
    endfunction

    function automatic t_coord max_c(input t_coord a, input t_coord b);
        return (b > a) ? b : a;
    endfunction

    // Configuration registers.
    logic [31:0] r_center [3];
    logic [30:0] r_half   [3];
    logic [23:0] r_first_slot;

    // Live split state, indexed [side][axis].
    logic [1:0]       r_empty,   n_empty;
    t_coord           r_low  [2][3], n_low  [2][3];
    t_coord           r_high [2][3], n_high [2][3];
    logic [CNT_W-1:0] r_cnt  [2],    n_cnt  [2];
    logic [CNT_W-1:0] r_item,        n_item;

    // Snapshot of both child boxes taken at the final triangle.
    logic [1:0]       r_s_empty, n_s_empty;
    t_coord           r_s_low  [2][3], n_s_low  [2][3];
    t_coord           r_s_high [2][3], n_s_high [2][3];
    logic [CNT_W-1:0] r_s_cnt  [2],    n_s_cnt  [2];

    t_phase   r_phase, n_phase;
    logic     r_out_valid, n_out_valid;
    t_res_out r_out, n_out;

    logic     out_free, in_acc;
    t_coord   ctr [3];
    t_coord   v   [3][3];
    logic [1:0] axis_xy, axis;
    logic signed [CW+1:0] sum, thr;
    logic     side;
    logic [23:0] slot;
    t_coord   g_low [3], g_high [3];
    t_res_out box_res;
    logic     box_side;
    logic signed [CW:0] b_sum [3], b_diff [3];
    t_coord   b_ctr [3];
    logic [CW-1:0] b_half [3];

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = out_free && (r_phase == PH_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ctr[k] = r_center[k][CW-1:0];
        end
        v[0][0] = i_in_data.ax[CW-1:0];
        v[0][1] = i_in_data.ay[CW-1:0];
        v[0][2] = i_in_data.az[CW-1:0];
        v[1][0] = i_in_data.bx[CW-1:0];
        v[1][1] = i_in_data.by[CW-1:0];
        v[1][2] = i_in_data.bz[CW-1:0];
        v[2][0] = i_in_data.cx[CW-1:0];
        v[2][1] = i_in_data.cy[CW-1:0];
        v[2][2] = i_in_data.cz[CW-1:0];

        // Ties between x and y go to y; z must be strictly longer to win.
        axis_xy = (r_half[0] > r_half[1]) ? AXIS_X : AXIS_Y;
        axis    = (r_half[2] > r_half[axis_xy]) ? AXIS_Z : axis_xy;

        sum = (CW+2)'(v[0][axis]) + (CW+2)'(v[1][axis]) + (CW+2)'(v[2][axis]);
        thr = ((CW+2)'(ctr[axis]) <<< 1) + (CW+2)'(ctr[axis]);
        side = (sum < thr) ? 1'b0 : 1'b1;

        slot = side ? (r_first_slot + 24'(r_item)) : (r_first_slot + 24'(r_cnt[0]));

        // The first vertex into an empty box is padded; the others only widen it.
        for (int k = 0; k < 3; k++) begin
            if (r_empty[side]) begin
                g_low[k]  = clamp_c((CW+1)'(v[0][k]) - PAD);
                g_high[k] = clamp_c((CW+1)'(v[0][k]) + PAD);
            end else begin
                g_low[k]  = min_c(r_low[side][k], v[0][k]);
                g_high[k] = max_c(r_high[side][k], v[0][k]);
            end
            g_low[k]  = min_c(min_c(g_low[k], v[1][k]), v[2][k]);
            g_high[k] = max_c(max_c(g_high[k], v[1][k]), v[2][k]);
        end
    end

    // Child box summary from the snapshot.
    always_comb begin
        box_side = (r_phase == PH_BOX1);
        for (int k = 0; k < 3; k++) begin
            b_sum[k]  = (CW+1)'(r_s_low[box_side][k]) + (CW+1)'(r_s_high[box_side][k]);
            b_diff[k] = (CW+1)'(r_s_high[box_side][k]) - (CW+1)'(r_s_low[box_side][k]);
            b_ctr[k]  = b_sum[k][CW:1];
            b_half[k] = b_diff[k][CW:1];
        end
        box_res      = '0;
        box_res.kind = KIND_BOX;
        box_res.side = box_side;
        if (!r_s_empty[box_side]) begin
            box_res.box_center_x = 32'(b_ctr[0]);
            box_res.box_center_y = 32'(b_ctr[1]);
            box_res.box_center_z = 32'(b_ctr[2]);
            box_res.box_half_x   = 31'(b_half[0]);
            box_res.box_half_y   = 31'(b_half[1]);
            box_res.box_half_z   = 31'(b_half[2]);
            box_res.child_count  = 17'(r_s_cnt[box_side]);
        end
        box_res.run_end = box_side;
    end

    always_comb begin
        n_empty   = r_empty;
        n_low     = r_low;
        n_high    = r_high;
        n_cnt     = r_cnt;
        n_item    = r_item;
        n_s_empty = r_s_empty;
        n_s_low   = r_s_low;
        n_s_high  = r_s_high;
        n_s_cnt   = r_s_cnt;
        n_phase   = r_phase;
        n_out_valid = r_out_valid;
        n_out     = r_out;

        if (in_acc) begin
            n_empty[side] = 1'b0;
            for (int k = 0; k < 3; k++) begin
                n_low[side][k]  = g_low[k];
                n_high[side][k] = g_high[k];
            end
            if (r_cnt[side] < CNT_MAX) begin
                n_cnt[side] = r_cnt[side] + 1'b1;
            end
            if (r_item < CNT_MAX) begin
                n_item = r_item + 1'b1;
            end
            if (i_in_data.final_tri) begin
                n_s_empty = n_empty;
                n_s_low   = n_low;
                n_s_high  = n_high;
                n_s_cnt   = n_cnt;
                n_empty   = 2'b11;
                n_cnt[0]  = '0;
                n_cnt[1]  = '0;
                n_item    = '0;
            end
        end

        if (out_free) begin
            unique case (r_phase)
                PH_BOX0: begin
                    n_out_valid = 1'b1;
                    n_out       = box_res;
                    n_phase     = PH_BOX1;
                end
                PH_BOX1: begin
                    n_out_valid = 1'b1;
                    n_out       = box_res;
                    n_phase     = PH_IDLE;
                end
                default: begin
                    n_out_valid = in_acc;
                    n_out         = '0;
                    n_out.kind    = KIND_PLACE;
                    n_out.side    = side;
                    n_out.slot    = slot;
                    n_out.run_end = !i_in_data.final_tri;
                    if (in_acc && i_in_data.final_tri) begin
                        n_phase = PH_BOX0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_center[k] <= '0;
                r_half[k]   <= '0;
            end
            r_first_slot <= '0;
            r_empty      <= 2'b11;
            r_cnt[0]     <= '0;
            r_cnt[1]     <= '0;
            r_item       <= '0;
            r_phase      <= PH_IDLE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CENTER_X: r_center[0]  <= i_cfg_data;
                    CFG_CENTER_Y: r_center[1]  <= i_cfg_data;
                    CFG_CENTER_Z: r_center[2]  <= i_cfg_data;
                    CFG_HALF_X:   r_half[0]    <= i_cfg_data[30:0];
                    CFG_HALF_Y:   r_half[1]    <= i_cfg_data[30:0];
                    CFG_HALF_Z:   r_half[2]    <= i_cfg_data[30:0];
                    CFG_FIRST:    r_first_slot <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            r_empty     <= n_empty;
            r_cnt       <= n_cnt;
            r_item      <= n_item;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
        r_low     <= n_low;
        r_high    <= n_high;
        r_s_empty <= n_s_empty;
        r_s_low   <= n_s_low;
        r_s_high  <= n_s_high;
        r_s_cnt   <= n_s_cnt;
        r_out     <= n_out;
    end

endmodule

>>> rtl/bvhms_checker.sv
// Port-level checks for the BVH midpoint split pass, bound to the top level.
// Depends on bvhms_pkg and bvh_midpoint_split_pass.
module bvhms_checker
    import bvhms_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [31:0]          i_cfg_data,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input t_tri_in              i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_res_out             o_out_data
);

    // Every accepted triangle shows its placement in the next cycle.
    a_place_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && o_in_ready |=>
            o_out_valid && (o_out_data.kind == KIND_PLACE))
        else $error("placement request missing after accepted triangle");

    // Box requests come first child then second; this checks that only the second ends the run.
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_BOX) |->
            (o_out_data.run_end == o_out_data.side))
        else $error("child box request with wrong run end");

    // While the final placement is shown, no new triangle may enter.
    a_hold_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_PLACE) && !o_out_data.run_end |->
            !o_in_ready)
        else $error("triangle accepted ahead of pending child boxes");

    // A stalled result request holds its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result request changed");

endmodule

bind bvh_midpoint_split_pass bvhms_checker u_bvhms_checker (.*);
